// ----- rtl/cwg_pkg.sv -----
// Package for the 5x5 weight gradient unit: sizes, register indexes,
// store request types and the dimension clamp. No dependencies.
`default_nettype none

package cwg_pkg;

  localparam int unsigned MaxWidth   = 64;
  localparam int unsigned MaxHeight  = 64;
  localparam int unsigned KernelSize = 5;
  localparam int unsigned TapCount   = KernelSize * KernelSize;
  localparam int unsigned PlaneDepth = MaxWidth * MaxHeight;
  localparam int unsigned PlaneAw    = $clog2(PlaneDepth);
  localparam int unsigned PosW       = $clog2(PlaneDepth + 1);
  localparam int unsigned CoordW     = $clog2(MaxWidth > MaxHeight ? MaxWidth : MaxHeight);
  localparam int unsigned DimW       = 7;
  localparam int unsigned TapW       = $clog2(TapCount);
  localparam int unsigned KW         = 3;
  localparam int unsigned PixW       = 16;
  localparam int unsigned ProdW      = 2 * PixW;
  localparam int unsigned SumW       = 56;
  localparam int unsigned OffW       = PlaneAw + 2;

  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef struct packed {
    logic                   sat;
    logic signed [SumW-1:0] sum;
  } acc_entry_t;

  typedef struct packed {
    logic            en;
    logic [TapW-1:0] addr;
    acc_entry_t      data;
  } acc_wr_t;

  typedef struct packed {
    logic               en;
    logic [PlaneAw-1:0] addr;
    logic [PixW-1:0]    in_value;
    logic [PixW-1:0]    grad_value;
  } plane_wr_t;

  // A zero dimension counts as one, anything above the maximum as the maximum.
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v,
                                               input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    if (v == '0) r = DimW'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cwg_if.sv -----
// Handshake channels of the weight gradient unit: pixel words in, tap words out.
// Depends on cwg_pkg.
`default_nettype none

interface cwg_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [cwg_pkg::PixW-1:0] in_value;
  logic signed [cwg_pkg::PixW-1:0] grad_value;
  logic                            last_pixel;
  logic                            last_image;
  modport source (output valid, in_value, grad_value, last_pixel, last_image, input ready);
  modport sink (input valid, in_value, grad_value, last_pixel, last_image, output ready);
endinterface

interface cwg_out_if;
  logic                            valid;
  logic                            ready;
  logic [cwg_pkg::KW-1:0]          tap_row;
  logic [cwg_pkg::KW-1:0]          tap_col;
  logic signed [cwg_pkg::SumW-1:0] grad_sum;
  logic                            saturated;
  logic                            last_tap;
  modport source (output valid, tap_row, tap_col, grad_sum, saturated, last_tap, input ready);
  modport sink (input valid, tap_row, tap_col, grad_sum, saturated, last_tap, output ready);
endinterface

`default_nettype wire

// ----- rtl/cwg_plane_store.sv -----
// Input and gradient plane memories, one write port shared, one read port each.
// Read data is registered. Depends on cwg_pkg.
`default_nettype none

module cwg_plane_store (
  input  wire logic                          clk_i,
  input  wire cwg_pkg::plane_wr_t            wr_i,
  input  wire logic [cwg_pkg::PlaneAw-1:0]   grad_addr_i,
  input  wire logic [cwg_pkg::PlaneAw-1:0]   in_addr_i,
  output logic      [cwg_pkg::PixW-1:0]      grad_data_o,
  output logic      [cwg_pkg::PixW-1:0]      in_data_o
);

  logic [cwg_pkg::PixW-1:0] in_mem   [cwg_pkg::PlaneDepth];
  logic [cwg_pkg::PixW-1:0] grad_mem [cwg_pkg::PlaneDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      in_mem[wr_i.addr]   <= wr_i.in_value;
      grad_mem[wr_i.addr] <= wr_i.grad_value;
    end
    grad_data_o <= grad_mem[grad_addr_i];
    in_data_o   <= in_mem[in_addr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/cwg_acc_store.sv -----
// Tap accumulator memory with per-entry valid bits; an invalid entry reads as zero.
// Depends on cwg_pkg.
`default_nettype none

module cwg_acc_store (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [cwg_pkg::TapW-1:0]   rd_addr_i,
  output cwg_pkg::acc_entry_t             rd_data_o,
  input  wire cwg_pkg::acc_wr_t           wr_i,
  input  wire logic                       clr_i,
  input  wire logic [cwg_pkg::TapW-1:0]   clr_addr_i
);

  cwg_pkg::acc_entry_t             mem [cwg_pkg::TapCount];
  logic [cwg_pkg::TapCount-1:0]    valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (wr_i.en) valid_q[wr_i.addr] <= 1'b1;
      if (clr_i) valid_q[clr_addr_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[wr_i.addr] <= wr_i.data;
    rd_data_o <= valid_q[rd_addr_i] ? mem[rd_addr_i] : '0;
  end

endmodule

`default_nettype wire

// ----- rtl/conv5x5_weight_gradient_unit.sv -----
// 5x5 weight gradient unit: loads a plane pair, then sweeps all taps with one MAC.
// Loading accepts one pixel word per cycle. At the last pixel the unit sweeps
// the 25 taps in turn with the one shared MAC and the single read port of each
// plane memory, taking no pixel words meanwhile; at batch end 25 tap words follow.
// Reset clears control state and all accumulators; plane contents are kept.
// Depends on cwg_pkg, cwg_if, cwg_plane_store and cwg_acc_store.
`default_nettype none

module conv5x5_weight_gradient_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  cwg_in_if.sink           pix_i,
  cwg_out_if.source        res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam logic [2:0] StLoad    = 3'd0;
  localparam logic [2:0] StTapInit = 3'd1;
  localparam logic [2:0] StTapLoad = 3'd2;
  localparam logic [2:0] StSweep   = 3'd3;
  localparam logic [2:0] StDrain   = 3'd4;
  localparam logic [2:0] StEmitRd  = 3'd5;
  localparam logic [2:0] StEmitLd  = 3'd6;

  localparam logic [cwg_pkg::DimW-1:0] MaxW = cwg_pkg::DimW'(cwg_pkg::MaxWidth);
  localparam logic [cwg_pkg::DimW-1:0] MaxH = cwg_pkg::DimW'(cwg_pkg::MaxHeight);
  localparam logic [cwg_pkg::TapW-1:0] LastTap = cwg_pkg::TapW'(cwg_pkg::TapCount - 1);
  localparam logic [cwg_pkg::KW-1:0]   LastK = cwg_pkg::KW'(cwg_pkg::KernelSize - 1);

  // Configuration registers.
  logic [cwg_pkg::DimW-1:0] width_q, height_q;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = paddr[2] == cwg_pkg::RegHeight ? 32'(height_q) : 32'(width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= MaxW;
      height_q <= MaxH;
    end else if (cfg_wr) begin
      if (paddr[2] == cwg_pkg::RegHeight) height_q <= pwdata[cwg_pkg::DimW-1:0];
      else width_q <= pwdata[cwg_pkg::DimW-1:0];
    end
  end

  // Control state.
  logic [2:0]                 state_q, state_d;
  logic [cwg_pkg::PosW-1:0]   pos_q, pos_d;
  logic [cwg_pkg::TapW-1:0]   tap_q, tap_d;
  logic [cwg_pkg::KW-1:0]     r_q, r_d, s_q, s_d;
  logic [cwg_pkg::CoordW-1:0] y_q, y_d, x_q, x_d;
  logic [cwg_pkg::PlaneAw-1:0] gaddr_q, gaddr_d;
  logic [cwg_pkg::OffW-1:0]   off_q, off_d;
  logic [cwg_pkg::DimW-1:0]   w_q, w_d, h_q, h_d;
  logic                       batch_end_q, batch_end_d;
  logic                       v1_q, v1_d, v2_q, b1_q, b1_d, b2_q;
  logic                       out_valid_q;

  // Datapath registers.
  logic signed [cwg_pkg::ProdW-1:0] prod_q;
  logic signed [cwg_pkg::SumW-1:0]  acc_q;
  logic                             sat_q;
  logic [cwg_pkg::KW-1:0]           out_row_q, out_col_q;
  logic signed [cwg_pkg::SumW-1:0]  out_sum_q;
  logic                             out_sat_q, out_last_q;

  logic                             accept, out_take, load_out;
  logic [cwg_pkg::DimW-1:0]         ew, eh;
  logic [cwg_pkg::PosW-1:0]         area;
  logic [7:0]                       iy, ix;
  logic [cwg_pkg::OffW-1:0]         iaddr_full;
  logic                             pos_ok, last_pos;

  cwg_pkg::plane_wr_t               plane_wr;
  logic [cwg_pkg::PixW-1:0]         grad_rd, in_rd;
  cwg_pkg::acc_entry_t              acc_rd;
  cwg_pkg::acc_wr_t                 acc_wr;
  logic                             acc_clr;
  logic signed [cwg_pkg::SumW:0]    sum;

  assign ew     = cwg_pkg::eff_dim(width_q, MaxW);
  assign eh     = cwg_pkg::eff_dim(height_q, MaxH);
  assign area   = cwg_pkg::PosW'(ew) * cwg_pkg::PosW'(eh);
  assign accept = pix_i.valid & pix_i.ready;
  assign pix_i.ready = state_q == StLoad;
  assign out_take = out_valid_q & res_o.ready;

  // Source coordinates of the current tap; negative values wrap high and fail the bound.
  assign iy = 8'(y_q) + 8'(r_q) - 8'd2;
  assign ix = 8'(x_q) + 8'(s_q) - 8'd2;
  assign pos_ok = (iy < 8'(h_q)) && (ix < 8'(w_q));
  assign iaddr_full = cwg_pkg::OffW'(gaddr_q) + off_q;
  assign last_pos = (7'(y_q) + 7'd1 == h_q) && (7'(x_q) + 7'd1 == w_q);

  assign plane_wr.en         = accept && (pos_q < area);
  assign plane_wr.addr       = pos_q[cwg_pkg::PlaneAw-1:0];
  assign plane_wr.in_value   = pix_i.in_value;
  assign plane_wr.grad_value = pix_i.grad_value;

  cwg_plane_store u_planes (
    .clk_i       (clk_i),
    .wr_i        (plane_wr),
    .grad_addr_i (gaddr_q),
    .in_addr_i   (iaddr_full[cwg_pkg::PlaneAw-1:0]),
    .grad_data_o (grad_rd),
    .in_data_o   (in_rd)
  );

  assign acc_wr.en       = state_q == StDrain && !b1_q && !b2_q;
  assign acc_wr.addr     = tap_q;
  assign acc_wr.data.sat = sat_q;
  assign acc_wr.data.sum = acc_q;
  assign load_out        = state_q == StEmitLd;
  assign acc_clr         = load_out;

  cwg_acc_store u_accs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (tap_q),
    .rd_data_o  (acc_rd),
    .wr_i       (acc_wr),
    .clr_i      (acc_clr),
    .clr_addr_i (tap_q)
  );

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    tap_d       = tap_q;
    r_d         = r_q;
    s_d         = s_q;
    y_d         = y_q;
    x_d         = x_q;
    gaddr_d     = gaddr_q;
    off_d       = off_q;
    w_d         = w_q;
    h_d         = h_q;
    batch_end_d = batch_end_q;
    v1_d        = 1'b0;
    b1_d        = 1'b0;
    unique case (state_q)
      StLoad: begin
        if (accept) begin
          if (pos_q < area) pos_d = pos_q + 1'b1;
          if (pix_i.last_pixel) begin
            pos_d       = '0;
            w_d         = ew;
            h_d         = eh;
            batch_end_d = pix_i.last_image;
            tap_d       = '0;
            r_d         = '0;
            s_d         = '0;
            state_d     = StTapInit;
          end
        end
      end
      StTapInit: begin
        // Offset from a gradient position to its input position: (r-2)*w + (s-2).
        off_d   = cwg_pkg::OffW'(r_q) * cwg_pkg::OffW'(w_q) + cwg_pkg::OffW'(s_q)
                - cwg_pkg::OffW'({w_q, 1'b0}) - cwg_pkg::OffW'(2);
        y_d     = '0;
        x_d     = '0;
        gaddr_d = '0;
        state_d = StTapLoad;
      end
      StTapLoad: begin
        state_d = StSweep;
      end
      StSweep: begin
        v1_d    = pos_ok;
        b1_d    = 1'b1;
        gaddr_d = gaddr_q + 1'b1;
        if (7'(x_q) + 7'd1 == w_q) begin
          x_d = '0;
          y_d = y_q + 1'b1;
        end else begin
          x_d = x_q + 1'b1;
        end
        if (last_pos) state_d = StDrain;
      end
      StDrain: begin
        if (!b1_q && !b2_q) begin
          if (tap_q == LastTap) begin
            tap_d   = '0;
            r_d     = '0;
            s_d     = '0;
            state_d = batch_end_q ? StEmitRd : StLoad;
          end else begin
            tap_d   = tap_q + 1'b1;
            state_d = StTapInit;
            if (s_q == LastK) begin
              s_d = '0;
              r_d = r_q + 1'b1;
            end else begin
              s_d = s_q + 1'b1;
            end
          end
        end
      end
      StEmitRd: begin
        if (!out_valid_q) state_d = StEmitLd;
      end
      StEmitLd: begin
        if (tap_q == LastTap) begin
          tap_d   = '0;
          r_d     = '0;
          s_d     = '0;
          state_d = StLoad;
        end else begin
          tap_d   = tap_q + 1'b1;
          state_d = StEmitRd;
          if (s_q == LastK) begin
            s_d = '0;
            r_d = r_q + 1'b1;
          end else begin
            s_d = s_q + 1'b1;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      pos_q       <= '0;
      tap_q       <= '0;
      r_q         <= '0;
      s_q         <= '0;
      y_q         <= '0;
      x_q         <= '0;
      gaddr_q     <= '0;
      off_q       <= '0;
      w_q         <= MaxW;
      h_q         <= MaxH;
      batch_end_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      b1_q        <= 1'b0;
      b2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      tap_q       <= tap_d;
      r_q         <= r_d;
      s_q         <= s_d;
      y_q         <= y_d;
      x_q         <= x_d;
      gaddr_q     <= gaddr_d;
      off_q       <= off_d;
      w_q         <= w_d;
      h_q         <= h_d;
      batch_end_q <= batch_end_d;
      v1_q        <= v1_d;
      v2_q        <= v1_q;
      b1_q        <= b1_d;
      b2_q        <= b1_q;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_take) out_valid_q <= 1'b0;
    end
  end

  // Product stage, then the saturating add into the running tap sum.
  assign sum = (cwg_pkg::SumW + 1)'(acc_q) + (cwg_pkg::SumW + 1)'(prod_q);

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(grad_rd) * $signed(in_rd);
    if (state_q == StTapLoad) begin
      acc_q <= acc_rd.sum;
      sat_q <= acc_rd.sat;
    end else if (v2_q) begin
      if (sum[cwg_pkg::SumW] != sum[cwg_pkg::SumW-1]) begin
        acc_q <= sum[cwg_pkg::SumW] ? {1'b1, {(cwg_pkg::SumW-1){1'b0}}}
                                    : {1'b0, {(cwg_pkg::SumW-1){1'b1}}};
        sat_q <= 1'b1;
      end else begin
        acc_q <= sum[cwg_pkg::SumW-1:0];
      end
    end
    if (load_out) begin
      out_row_q  <= r_q;
      out_col_q  <= s_q;
      out_sum_q  <= acc_rd.sum;
      out_sat_q  <= acc_rd.sat;
      out_last_q <= tap_q == LastTap;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.tap_row   = out_row_q;
  assign res_o.tap_col   = out_col_q;
  assign res_o.grad_sum  = out_sum_q;
  assign res_o.saturated = out_sat_q;
  assign res_o.last_tap  = out_last_q;

  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_q <= LastTap) else $error("tap index out of range");
  a_wb_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_wr.en |-> !v1_q && !v2_q) else $error("write-back with products in flight");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLoad |-> !b1_q && !b2_q) else $error("pipeline busy while loading");
  a_last_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_row_q == LastK && out_col_q == LastK)
    else $error("last tap word is not the corner tap");

endmodule

`default_nettype wire

// ----- tb/conv5x5_weight_gradient_unit_tb.sv -----
// Self-checking testbench for the 5x5 weight gradient unit: random plane pairs
// at many plane sizes, checked tap by tap against a predictor in a scoreboard.
// Depends on cwg_pkg, cwg_if and the unit itself.
`timescale 1ns / 100ps

module conv5x5_weight_gradient_unit_tb;

  typedef struct {
    logic signed [cwg_pkg::PixW-1:0] in_value;
    logic signed [cwg_pkg::PixW-1:0] grad_value;
    logic                            last_pixel;
    logic                            last_image;
  } pixel_word_t;

  typedef struct {
    logic [cwg_pkg::KW-1:0]          tap_row;
    logic [cwg_pkg::KW-1:0]          tap_col;
    logic signed [cwg_pkg::SumW-1:0] grad_sum;
    logic                            saturated;
    logic                            last_tap;
  } tap_word_t;

  class tap_scoreboard;
    int unsigned                     width_eff = cwg_pkg::MaxWidth;
    int unsigned                     height_eff = cwg_pkg::MaxHeight;
    logic signed [cwg_pkg::PixW-1:0] act_plane[cwg_pkg::PlaneDepth];
    logic signed [cwg_pkg::PixW-1:0] grad_plane[cwg_pkg::PlaneDepth];
    longint                          tap_acc[cwg_pkg::TapCount];
    bit                              tap_clip[cwg_pkg::TapCount];
    int unsigned                     fill_pos;
    tap_word_t                       pending_taps[$];
    int                              errors;

    function void set_dim(logic reg_idx, logic [cwg_pkg::DimW-1:0] v);
      int unsigned lim;
      int unsigned d;
      lim = (reg_idx == cwg_pkg::RegWidth) ? cwg_pkg::MaxWidth : cwg_pkg::MaxHeight;
      d = (v == 0) ? 1 : ((v > lim) ? lim : v);
      if (reg_idx == cwg_pkg::RegWidth) width_eff = d;
      else height_eff = d;
    endfunction

    function void sweep_taps();
      longint lim_hi;
      longint lim_lo;
      longint s;
      int     iy;
      int     ix;
      int     t;
      lim_hi = 64'sd36028797018963967;
      lim_lo = -lim_hi - 1;
      for (int r = 0; r < cwg_pkg::KernelSize; r++) begin
        for (int c = 0; c < cwg_pkg::KernelSize; c++) begin
          t = r * cwg_pkg::KernelSize + c;
          for (int y = 0; y < height_eff; y++) begin
            iy = y + r - 2;
            if (iy < 0 || iy >= height_eff) continue;
            for (int x = 0; x < width_eff; x++) begin
              ix = x + c - 2;
              if (ix < 0 || ix >= width_eff) continue;
              s = tap_acc[t] + longint'(grad_plane[y*width_eff+x]) *
                  longint'(act_plane[iy*width_eff+ix]);
              if (s > lim_hi) begin
                s = lim_hi;
                tap_clip[t] = 1;
              end
              if (s < lim_lo) begin
                s = lim_lo;
                tap_clip[t] = 1;
              end
              tap_acc[t] = s;
            end
          end
        end
      end
    endfunction

    function void note_pixel(pixel_word_t p);
      tap_word_t t;
      if (fill_pos < width_eff * height_eff) begin
        act_plane[fill_pos] = p.in_value;
        grad_plane[fill_pos] = p.grad_value;
        fill_pos++;
      end
      if (!p.last_pixel) return;
      sweep_taps();
      fill_pos = 0;
      if (!p.last_image) return;
      for (int k = 0; k < cwg_pkg::TapCount; k++) begin
        t.tap_row = k / cwg_pkg::KernelSize;
        t.tap_col = k % cwg_pkg::KernelSize;
        t.grad_sum = tap_acc[k][cwg_pkg::SumW-1:0];
        t.saturated = tap_clip[k];
        t.last_tap = (k == cwg_pkg::TapCount - 1);
        pending_taps.push_back(t);
        tap_acc[k] = 0;
        tap_clip[k] = 0;
      end
    endfunction

    function void check_tap(tap_word_t a);
      tap_word_t e;
      if (pending_taps.size() == 0) begin
        $display("%0t: unexpected tap word row %0d col %0d sum %0d", $time,
                 a.tap_row, a.tap_col, a.grad_sum);
        errors++;
        return;
      end
      e = pending_taps.pop_front();
      if (a.tap_row !== e.tap_row || a.tap_col !== e.tap_col ||
          a.grad_sum !== e.grad_sum || a.saturated !== e.saturated ||
          a.last_tap !== e.last_tap) begin
        $display("%0t: tap mismatch expected row %0d col %0d sum %0d sat %0d last %0d",
                 $time, e.tap_row, e.tap_col, e.grad_sum, e.saturated, e.last_tap);
        $display("%0t:              actual   row %0d col %0d sum %0d sat %0d last %0d",
                 $time, a.tap_row, a.tap_col, a.grad_sum, a.saturated, a.last_tap);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cwg_in_if  pix ();
  cwg_out_if res ();

  conv5x5_weight_gradient_unit i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .pix_i   (pix),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tap_scoreboard tap_sb = new();
  pixel_word_t   pixel_q[$];
  int            hold_left;
  int unsigned   written_extent;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver: a long hold when asked, otherwise stretches of random stalls
  // alternating with stretches of steady readiness.
  initial begin
    tap_word_t   got;
    int unsigned cyc;
    cyc = 0;
    res.ready = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (res.valid && res.ready) begin
        got.tap_row = res.tap_row;
        got.tap_col = res.tap_col;
        got.grad_sum = res.grad_sum;
        got.saturated = res.saturated;
        got.last_tap = res.last_tap;
        tap_sb.check_tap(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (cyc[7]) begin
        res.ready <= 1'b1;
      end else begin
        res.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  initial begin
    #25ms;
    $display("conv5x5_weight_gradient_unit_tb: errors");
    $finish;
  end

  task automatic write_reg(logic reg_idx, logic [cwg_pkg::DimW-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tap_sb.set_dim(reg_idx, v);
    written_extent = 0;
  endtask

  function automatic logic signed [cwg_pkg::PixW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return cwg_pkg::PixW'($urandom);
    endcase
  endfunction

  // Queues one image of n words; an early last_image alone is ignored by the unit.
  task automatic queue_image(int unsigned n, bit last_img);
    pixel_word_t p;
    for (int unsigned i = 0; i < n; i++) begin
      p.in_value = pick_value();
      p.grad_value = pick_value();
      p.last_pixel = (i == n - 1);
      p.last_image = (i == n - 1) ? last_img : ($urandom_range(0, 19) == 0);
      pixel_q.push_back(p);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  task automatic send_queued();
    int burst_left;
    int gap;
    burst_left = 0;
    while (pixel_q.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          pix.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      pix.valid <= 1'b1;
      pix.in_value <= pixel_q[0].in_value;
      pix.grad_value <= pixel_q[0].grad_value;
      pix.last_pixel <= pixel_q[0].last_pixel;
      pix.last_image <= pixel_q[0].last_image;
      do @(posedge clk); while (!(pix.valid && pix.ready));
      tap_sb.note_pixel(pixel_q.pop_front());
      burst_left--;
    end
    pix.valid <= 1'b0;
  endtask

  task automatic drain();
    while (tap_sb.pending_taps.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    logic [cwg_pkg::DimW-1:0] wv[10] = '{1, 0, 5, 127, 1, 3, 8, 2, 64, 4};
    logic [cwg_pkg::DimW-1:0] hv[10] = '{1, 3, 5, 1, 64, 4, 2, 7, 1, 0};
    pixel_word_t     p;
    int unsigned     area;
    int unsigned     n;
    int unsigned     phase_items;
    int unsigned     limit;
    bit              closed;
    bit              last_img;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix.valid = 1'b0;
    pix.in_value = '0;
    pix.grad_value = '0;
    pix.last_pixel = 1'b0;
    pix.last_image = 1'b0;
    hold_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a 1x1 plane with the extreme products, one image each.
    write_reg(cwg_pkg::RegWidth, 1);
    write_reg(cwg_pkg::RegHeight, 1);
    for (int i = 0; i < 5; i++) begin
      p.in_value = (i == 1 || i == 3) ? 16'sh7fff : 16'sh8000;
      p.grad_value = (i >= 2) ? 16'sh7fff : 16'sh8000;
      if (i == 4) p.grad_value = 16'sh0000;
      p.last_pixel = 1'b1;
      p.last_image = (i == 4);
      pixel_q.push_back(p);
    end
    send_queued();
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(cwg_pkg::RegWidth, wv[ph]);
      write_reg(cwg_pkg::RegHeight, hv[ph]);
      area = tap_sb.width_eff * tap_sb.height_eff;
      // In the pressure phase every image ends a batch, so the long hold on the
      // result side meets tap words while the next image is still offered.
      limit = (ph == 2) ? 50 : 12;
      if (ph == 2) hold_left = 3000;
      phase_items = 0;
      closed = 0;
      while (!closed) begin
        case ($urandom_range(0, 5))
          0: n = area + $urandom_range(1, 3);
          1: n = (written_extent >= area && area > 1) ? $urandom_range(1, area - 1) : area;
          default: n = area;
        endcase
        if (n > written_extent) written_extent = (n > area) ? area : n;
        phase_items += n;
        last_img = ($urandom_range(0, 2) == 0) || phase_items >= limit || ph == 2;
        queue_image(n, last_img);
        closed = last_img && phase_items >= limit;
      end
      send_queued();
      drain();
    end

    if (tap_sb.errors == 0) begin
      $display("conv5x5_weight_gradient_unit_tb: clean");
    end else begin
      $display("conv5x5_weight_gradient_unit_tb: errors");
    end
    $finish;
  end

endmodule
